@@ hw/rtl/cpa_pkg.sv @@
// shared types and constants for the contiguous page allocator
`timescale 1ns / 1ps

package cpa_pkg;

   // payload field widths
   localparam int KIND_BITS        = 1;
   localparam int POLICY_BITS      = 2;
   localparam int OWNER_FIELD_BITS = 16;
   localparam int PAGES_BITS       = 9;
   localparam int STATUS_BITS      = 2;
   localparam int START_BITS       = 8;

   // packed stream widths, padded to whole bytes
   localparam int REQ_FIELD_BITS = POLICY_BITS + OWNER_FIELD_BITS + PAGES_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = STATUS_BITS + START_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // parameter defaults
   localparam int DEF_PAGE_COUNT = 256;
   localparam int DEF_OWNER_BITS = 16;

   // item kinds
   localparam logic [KIND_BITS-1:0] KIND_ALLOC   = 1'b0;
   localparam logic [KIND_BITS-1:0] KIND_RELEASE = 1'b1;

   // placement policies
   localparam logic [POLICY_BITS-1:0] POLICY_FIRST = 2'd0;
   localparam logic [POLICY_BITS-1:0] POLICY_BEST  = 2'd1;
   localparam logic [POLICY_BITS-1:0] POLICY_WORST = 2'd2;
   localparam logic [POLICY_BITS-1:0] POLICY_BAD   = 2'd3;

   // result status codes
   localparam logic [STATUS_BITS-1:0] STATUS_ALLOCATED = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NO_FIT    = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_RELEASED  = 2'd2;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN_ALLOC,
      ST_DECIDE,
      ST_FILL,
      ST_SCAN_REL,
      ST_DONE
   } seq_state_type;

endpackage

@@ hw/rtl/contiguous_page_allocator.sv @@
// contiguous page allocator: first, best and worst fit over a page map memory
`timescale 1ns / 1ps

// channel  dir  handshake             payload
// req      in   req_tvalid/tready     tuser: kind; tdata: policy, owner, pages
// rsp      out  rsp_tvalid/tready     tdata: status, start_page
//
// an allocation scans the whole page map, one page map read per cycle, then decides in
// the decide state, writes one page per cycle in the fill state and loads the result in
// the done state; a request that finds no run skips the writes
// a release scans the whole map: read, compare and write back per page
// a zero count or unknown policy goes from idle straight to the done state, without a scan
// after reset a clearing pass frees every page; no item is taken until it is over
// a waiting result holds the sequencer in its last step until rsp_tready

module contiguous_page_allocator #(
   parameter int PAGE_COUNT = cpa_pkg::DEF_PAGE_COUNT,
   parameter int OWNER_BITS = cpa_pkg::DEF_OWNER_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // kind
   input  logic [cpa_pkg::KIND_BITS-1:0]     req_tuser,
   // policy[1:0], owner[17:2], pages[26:18], zero[31:27]
   input  logic [cpa_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status[1:0], start_page[9:2], zero[15:10]
   output logic [cpa_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import cpa_pkg::*;

   localparam int ADDR_BITS = $clog2(PAGE_COUNT);
   localparam int CNT_BITS  = $clog2(PAGE_COUNT + 1);
   localparam int LEN_BITS  = (CNT_BITS > PAGES_BITS) ? CNT_BITS : PAGES_BITS;
   localparam logic [CNT_BITS-1:0] LAST_PAGE = CNT_BITS'(PAGE_COUNT - 1);
   localparam logic [CNT_BITS-1:0] END_PAGE  = CNT_BITS'(PAGE_COUNT);

   // request fields
   logic [POLICY_BITS-1:0]      req_policy;
   logic [OWNER_FIELD_BITS-1:0] req_owner;
   logic [PAGES_BITS-1:0]       req_pages;
   logic [OWNER_BITS+OWNER_FIELD_BITS-1:0] owner_ext;
   logic [OWNER_BITS-1:0]       req_key;

   assign req_policy = req_tdata[POLICY_BITS-1:0];
   assign req_owner  = req_tdata[POLICY_BITS +: OWNER_FIELD_BITS];
   assign req_pages  = req_tdata[POLICY_BITS+OWNER_FIELD_BITS +: PAGES_BITS];
   // only the low OWNER_BITS of the owner id are kept
   assign owner_ext  = {{OWNER_BITS{1'b0}}, req_owner};
   assign req_key    = owner_ext[OWNER_BITS-1:0];

   // page map: taken bit above the owner id
   logic [OWNER_BITS:0] page_mem [PAGE_COUNT];
   logic                mem_we;
   logic [ADDR_BITS-1:0] mem_waddr;
   logic [OWNER_BITS:0]  mem_wdata;
   logic [ADDR_BITS-1:0] mem_raddr;
   logic [OWNER_BITS:0]  rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         page_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= page_mem[mem_raddr];
   end

   // sequencer and datapath registers
   seq_state_type state_ff, state_in;
   logic [CNT_BITS-1:0]    scan_addr_ff, scan_addr_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic [ADDR_BITS-1:0]   proc_idx_ff, proc_idx_in;
   logic [POLICY_BITS-1:0] policy_ff, policy_in;
   logic [OWNER_BITS-1:0]  key_ff, key_in;
   logic [LEN_BITS-1:0]    need_ff, need_in;
   logic [ADDR_BITS-1:0]   run_start_ff, run_start_in;
   logic [LEN_BITS-1:0]    run_len_ff, run_len_in;
   logic                   found_ff, found_in;
   logic [ADDR_BITS-1:0]   pick_start_ff, pick_start_in;
   logic [LEN_BITS-1:0]    pick_len_ff, pick_len_in;
   logic [ADDR_BITS-1:0]   fill_addr_ff, fill_addr_in;
   logic [LEN_BITS-1:0]    fill_left_ff, fill_left_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic [START_BITS-1:0]  start_ff, start_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic req_fire;
   logic scan_done;
   logic rsp_free;
   logic alloc_ok;
   logic [ADDR_BITS+START_BITS-1:0] pick_ext;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign scan_done  = (scan_addr_ff == END_PAGE) && !rd_valid_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign alloc_ok   = found_ff && (pick_len_ff >= need_ff);
   assign pick_ext   = {{START_BITS{1'b0}}, pick_start_ff};
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // run compare unit: a free page grows the run, a taken page or the
   // end of the map closes it and weighs it against the current pick
   logic sample_taken;
   logic close_run;
   logic fits;
   logic take_run;

   always_comb begin
      sample_taken = rd_valid_ff ? rd_data_ff[OWNER_BITS] : 1'b1;
      close_run    = sample_taken && (run_len_ff != '0);
      fits         = (run_len_ff >= need_ff);
      case (policy_ff)
         POLICY_FIRST: take_run = !found_ff && fits;
         POLICY_BEST:  take_run = fits && (!found_ff || (run_len_ff < pick_len_ff));
         POLICY_WORST: take_run = !found_ff || (run_len_ff > pick_len_ff);
         default:      take_run = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (scan_addr_ff == LAST_PAGE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == KIND_RELEASE) begin
                  state_in = ST_SCAN_REL;
               end else if ((req_pages == '0) || (req_policy == POLICY_BAD)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN_ALLOC;
               end
            end
         end
         ST_SCAN_ALLOC: begin
            if (scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = alloc_ok ? ST_FILL : ST_DONE;
         end
         ST_FILL: begin
            if (fill_left_ff == LEN_BITS'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN_REL: begin
            if (scan_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory port control
   always_comb begin
      scan_addr_in  = scan_addr_ff;
      rd_valid_in   = 1'b0;
      proc_idx_in   = proc_idx_ff;
      policy_in     = policy_ff;
      key_in        = key_ff;
      need_in       = need_ff;
      run_start_in  = run_start_ff;
      run_len_in    = run_len_ff;
      found_in      = found_ff;
      pick_start_in = pick_start_ff;
      pick_len_in   = pick_len_ff;
      fill_addr_in  = fill_addr_ff;
      fill_left_in  = fill_left_ff;
      status_in     = status_ff;
      start_in      = start_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_waddr     = scan_addr_ff[ADDR_BITS-1:0];
      mem_wdata     = '0;
      mem_raddr     = scan_addr_ff[ADDR_BITS-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            // free every page, one entry a cycle
            mem_we       = 1'b1;
            scan_addr_in = (scan_addr_ff == LAST_PAGE) ? '0 : scan_addr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_fire) begin
               policy_in    = req_policy;
               key_in       = req_key;
               need_in      = LEN_BITS'(req_pages);
               scan_addr_in = '0;
               run_len_in   = '0;
               found_in     = 1'b0;
               pick_len_in  = '0;
               start_in     = '0;
               status_in    = (req_tuser == KIND_RELEASE) ? STATUS_RELEASED : STATUS_NO_FIT;
            end
         end
         ST_SCAN_ALLOC: begin
            if (scan_addr_ff != END_PAGE) begin
               rd_valid_in  = 1'b1;
               proc_idx_in  = scan_addr_ff[ADDR_BITS-1:0];
               scan_addr_in = scan_addr_ff + 1'b1;
            end
            if (rd_valid_ff || scan_done) begin
               if (!sample_taken) begin
                  if (run_len_ff == '0) begin
                     run_start_in = proc_idx_ff;
                  end
                  run_len_in = run_len_ff + 1'b1;
               end else begin
                  run_len_in = '0;
                  if (close_run && take_run) begin
                     found_in      = 1'b1;
                     pick_start_in = run_start_ff;
                     pick_len_in   = run_len_ff;
                  end
               end
            end
         end
         ST_DECIDE: begin
            fill_addr_in = pick_start_ff;
            fill_left_in = need_ff;
            if (alloc_ok) begin
               status_in = STATUS_ALLOCATED;
               start_in  = pick_ext[START_BITS-1:0];
            end
         end
         ST_FILL: begin
            mem_we       = 1'b1;
            mem_waddr    = fill_addr_ff;
            mem_wdata    = {1'b1, key_ff};
            fill_addr_in = fill_addr_ff + 1'b1;
            fill_left_in = fill_left_ff - 1'b1;
         end
         ST_SCAN_REL: begin
            if (scan_addr_ff != END_PAGE) begin
               rd_valid_in  = 1'b1;
               proc_idx_in  = scan_addr_ff[ADDR_BITS-1:0];
               scan_addr_in = scan_addr_ff + 1'b1;
            end
            // write back a freed page in the cycle after its read
            if (rd_valid_ff && rd_data_ff[OWNER_BITS]
                  && (rd_data_ff[OWNER_BITS-1:0] == key_ff)) begin
               mem_we    = 1'b1;
               mem_waddr = proc_idx_ff;
               mem_wdata = {1'b0, key_ff};
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_BITS'({start_ff, status_ff});
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_addr_ff <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_addr_ff <= scan_addr_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      proc_idx_ff   <= proc_idx_in;
      policy_ff     <= policy_in;
      key_ff        <= key_in;
      need_ff       <= need_in;
      run_start_ff  <= run_start_in;
      run_len_ff    <= run_len_in;
      found_ff      <= found_in;
      pick_start_ff <= pick_start_in;
      pick_len_ff   <= pick_len_in;
      fill_addr_ff  <= fill_addr_in;
      fill_left_ff  <= fill_left_in;
      status_ff     <= status_in;
      start_ff      <= start_in;
      rsp_data_ff   <= rsp_data_in;
   end

`ifndef SYNTH
   // the scan counter never runs past the end of the map
   assert property (@(posedge clock) disable iff (reset) scan_addr_ff <= END_PAGE)
      else $error("scan counter out of range");

   // read data is only in flight during a scan
   assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> ((state_ff == ST_SCAN_ALLOC) || (state_ff == ST_SCAN_REL)))
      else $error("page read outside a scan");

   // the fill never writes more pages than were asked for
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> (fill_left_ff != '0))
      else $error("fill ran past its count");

   // a picked run is never empty
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DECIDE) && found_ff) |-> (pick_len_ff != '0))
      else $error("empty run picked");

   // an accepted item always starts work
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("item accepted without work");
`endif

endmodule

@@ sim/page_map_checker.sv @@
// checker for the contiguous page allocator: tracks the page map and compares every result
`timescale 1ns / 1ps

module page_map_checker #(
   parameter int PAGE_COUNT = cpa_pkg::DEF_PAGE_COUNT,
   parameter int OWNER_BITS = cpa_pkg::DEF_OWNER_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [cpa_pkg::KIND_BITS-1:0]     req_tuser,
   input  logic [cpa_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [cpa_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output int unsigned                       error_count,
   output int unsigned                       pending_count
);
   import cpa_pkg::*;

   localparam int OWNER_LO = POLICY_BITS;
   localparam int PAGES_LO = POLICY_BITS + OWNER_FIELD_BITS;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [START_BITS-1:0]  start_page;
   } alloc_answer_type;

   alloc_answer_type      answers_due [$];
   bit                    page_busy   [PAGE_COUNT];
   logic [OWNER_BITS-1:0] page_holder [PAGE_COUNT];

   // one pass over the map, runs closed by a taken page or the end of the pool
   function automatic bit place_run(input logic [POLICY_BITS-1:0] policy, input int need,
                                    output int at);
      int i;
      int run_start;
      int run_len;
      int pick_start;
      int pick_len;
      bit found;
      bit grab;
      run_start  = 0;
      run_len    = 0;
      pick_start = 0;
      pick_len   = 0;
      found      = 1'b0;
      for (i = 0; i <= PAGE_COUNT; i++) begin
         if (i < PAGE_COUNT && !page_busy[i]) begin
            if (run_len == 0) run_start = i;
            run_len++;
         end else begin
            if (run_len != 0) begin
               case (policy)
                  POLICY_FIRST: grab = !found && run_len >= need;
                  POLICY_BEST:  grab = run_len >= need && (!found || run_len < pick_len);
                  default:      grab = !found || run_len > pick_len;
               endcase
               if (grab) begin
                  found      = 1'b1;
                  pick_start = run_start;
                  pick_len   = run_len;
               end
            end
            run_len = 0;
         end
      end
      at = pick_start;
      return found && pick_len >= need;
   endfunction

   function automatic alloc_answer_type apply_item(input logic [KIND_BITS-1:0] kind,
                                                   input logic [POLICY_BITS-1:0] policy,
                                                   input logic [OWNER_FIELD_BITS-1:0] owner,
                                                   input logic [PAGES_BITS-1:0] pages);
      alloc_answer_type answer;
      logic [OWNER_BITS-1:0] who;
      int at;
      int i;
      who = owner[OWNER_BITS-1:0];
      answer.start_page = '0;
      if (kind == KIND_RELEASE) begin
         for (i = 0; i < PAGE_COUNT; i++)
            if (page_busy[i] && page_holder[i] == who) page_busy[i] = 1'b0;
         answer.status = STATUS_RELEASED;
      end else if (pages == 0 || policy == POLICY_BAD || !place_run(policy, int'(pages), at)) begin
         answer.status = STATUS_NO_FIT;
      end else begin
         for (i = at; i < at + int'(pages) && i < PAGE_COUNT; i++) begin
            page_busy[i]   = 1'b1;
            page_holder[i] = who;
         end
         answer.status     = STATUS_ALLOCATED;
         answer.start_page = at[START_BITS-1:0];
      end
      return answer;
   endfunction

   always @(posedge clock) begin : watch
      alloc_answer_type want;
      alloc_answer_type got;
      bit bad;
      if (reset) begin
         answers_due.delete();
         foreach (page_busy[i]) page_busy[i] = 1'b0;
         error_count   <= 0;
         pending_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            answers_due.push_back(apply_item(req_tuser,
                                             req_tdata[POLICY_BITS-1:0],
                                             req_tdata[OWNER_LO +: OWNER_FIELD_BITS],
                                             req_tdata[PAGES_LO +: PAGES_BITS]));
         if (rsp_tvalid && rsp_tready) begin
            got.status     = rsp_tdata[STATUS_BITS-1:0];
            got.start_page = rsp_tdata[STATUS_BITS +: START_BITS];
            bad = 1'b0;
            if (answers_due.size() == 0) begin
               $display("%0t: unexpected result, status %0d start_page %0d",
                        $time, got.status, got.start_page);
               bad = 1'b1;
            end else begin
               want = answers_due.pop_front();
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d, got %0d",
                           $time, want.status, got.status);
                  bad = 1'b1;
               end
               if (got.start_page !== want.start_page) begin
                  $display("%0t: start_page expected %0d, got %0d",
                           $time, want.start_page, got.start_page);
                  bad = 1'b1;
               end
            end
            if (bad) error_count <= error_count + 1;
         end
         pending_count <= answers_due.size();
      end
   end

endmodule

@@ sim/contiguous_page_allocator_tb.sv @@
// testbench top for the contiguous page allocator: stimulus, flow control and verdict
`timescale 1ns / 1ps

module contiguous_page_allocator_tb;
   import cpa_pkg::*;

   localparam int     PAGE_COUNT   = DEF_PAGE_COUNT;
   localparam int     RANDOM_ITEMS = 1830;
   localparam int     POOL_SIZE    = 8;
   // long receiver hold-off, well beyond one item's scan time
   localparam int     LONG_HOLD    = 3000;
   // slowest item is a full scan plus a full fill, plus gaps and stalls, taken several times
   localparam longint RUN_LIMIT    = 12_000_000;

   // fixed owners for the directed part, extremes of the owner field among them
   localparam logic [OWNER_FIELD_BITS-1:0] OWN_A = 16'h0000;
   localparam logic [OWNER_FIELD_BITS-1:0] OWN_B = 16'hFFFF;
   localparam logic [OWNER_FIELD_BITS-1:0] OWN_C = 16'h1234;
   localparam logic [OWNER_FIELD_BITS-1:0] OWN_D = 16'hA5C3;
   localparam logic [OWNER_FIELD_BITS-1:0] OWN_E = 16'h7E81;

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [KIND_BITS-1:0]       req_tuser;      // kind
   logic [REQ_DATA_BITS-1:0]   req_tdata;      // policy, owner, pages, zero pad
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [RSP_DATA_BITS-1:0]   rsp_tdata;      // status, start_page, zero pad

   int unsigned                error_count;
   int unsigned                pending_count;
   int unsigned                hold_requests = 0;
   int                         burst_left = 0;
   logic [OWNER_FIELD_BITS-1:0] owner_pool [POOL_SIZE];

   contiguous_page_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // watches both channels, predicts each result and counts mismatches
   page_map_checker #(
      .PAGE_COUNT (PAGE_COUNT),
      .OWNER_BITS (DEF_OWNER_BITS)
   ) page_map_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tuser     (req_tuser),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // present one item, hold it until taken, then maybe open a gap before the next burst
   // tready is looked at on the falling edge, where it is settled, so no race at the rising edge
   task automatic offer_item(input logic [KIND_BITS-1:0] kind,
                             input logic [POLICY_BITS-1:0] policy,
                             input logic [OWNER_FIELD_BITS-1:0] owner,
                             input logic [PAGES_BITS-1:0] pages);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_DATA_BITS'({pages, owner, policy});
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      // bursts of random length, a quarter of them run straight into the next one
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // sender goes quiet until every predicted result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // receiver: stretches of full, half and sparse readiness, plus long hold-offs on request
   initial begin : receiver
      int unsigned holds_served;
      int stretch;
      int ready_pct;
      holds_served = 0;
      rsp_tready <= 1'b0;
      forever begin
         if (hold_requests != holds_served) begin
            holds_served++;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            stretch = $urandom_range(20, 400);
            case ($urandom_range(0, 2))
               0:       ready_pct = 100;
               1:       ready_pct = 50;
               default: ready_pct = 20;
            endcase
            repeat (stretch) begin
               rsp_tready <= ($urandom_range(1, 100) <= ready_pct);
               @(posedge clock);
            end
         end
      end
   end

   // hard stop if the block hangs
   initial begin : watchdog
      longint cycles;
      cycles = 0;
      while (cycles < RUN_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("contiguous_page_allocator_tb: errors");
      $finish;
   end

   initial begin : stimulus
      int i;
      int r;
      logic [KIND_BITS-1:0]        kind;
      logic [POLICY_BITS-1:0]      policy;
      logic [OWNER_FIELD_BITS-1:0] owner;
      logic [PAGES_BITS-1:0]       pages;

      req_tvalid <= 1'b0;
      req_tuser  <= '0;
      req_tdata  <= '0;
      reset      <= 1'b1;
      for (i = 0; i < POOL_SIZE; i++) begin
         owner_pool[i] = OWNER_FIELD_BITS'($urandom_range(0, 65535));
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // refusals: zero pages, unknown policy, counts beyond the pool
      offer_item(KIND_ALLOC, POLICY_FIRST, OWN_A, 9'd0);
      offer_item(KIND_ALLOC, POLICY_BAD,   OWN_A, 9'd4);
      offer_item(KIND_ALLOC, POLICY_BEST,  OWN_A, 9'd257);
      offer_item(KIND_ALLOC, POLICY_WORST, OWN_B, 9'd511);
      // whole pool to one owner, then nothing fits
      offer_item(KIND_ALLOC, POLICY_FIRST, OWN_A, 9'd256);
      offer_item(KIND_ALLOC, POLICY_BEST,  OWN_B, 9'd1);
      // release of an owner holding nothing, then the full release
      offer_item(KIND_RELEASE, POLICY_FIRST, OWN_B, 9'd0);
      offer_item(KIND_RELEASE, POLICY_WORST, OWN_A, 9'd3);
      // build a fragmented map: holes of 5 and 3 pages plus a long tail
      offer_item(KIND_ALLOC, POLICY_FIRST, OWN_A, 9'd10);
      offer_item(KIND_ALLOC, POLICY_FIRST, OWN_B, 9'd5);
      offer_item(KIND_ALLOC, POLICY_BEST,  OWN_C, 9'd20);
      offer_item(KIND_ALLOC, POLICY_WORST, OWN_D, 9'd3);
      offer_item(KIND_ALLOC, POLICY_FIRST, OWN_E, 9'd30);
      offer_item(KIND_RELEASE, POLICY_FIRST, OWN_B, 9'd0);
      offer_item(KIND_RELEASE, POLICY_FIRST, OWN_D, 9'd0);
      // best fit lands in the exact hole, worst fit in the tail
      offer_item(KIND_ALLOC, POLICY_BEST,  OWN_C, 9'd3);
      offer_item(KIND_ALLOC, POLICY_WORST, OWN_A, 9'd100);
      // worst fit whose largest run is too small
      offer_item(KIND_ALLOC, POLICY_WORST, OWN_B, 9'd200);
      offer_item(KIND_ALLOC, POLICY_FIRST, OWN_B, 9'd4);
      offer_item(KIND_ALLOC, POLICY_BEST,  OWN_D, 9'd1);
      // owners, some spread over several runs, freed one by one until the map is empty
      offer_item(KIND_RELEASE, POLICY_FIRST, OWN_A, 9'd0);
      offer_item(KIND_RELEASE, POLICY_FIRST, OWN_C, 9'd0);
      offer_item(KIND_RELEASE, POLICY_FIRST, OWN_E, 9'd0);
      offer_item(KIND_RELEASE, POLICY_FIRST, OWN_B, 9'd0);
      offer_item(KIND_RELEASE, POLICY_FIRST, OWN_D, 9'd0);
      wait_drained();

      // random part: mostly allocations and releases within a small owner pool,
      // so the map fills, fragments and merges; the rest is refusals and stray owners
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         // long receiver hold-off while the sender keeps offering items
         if (i == 300) hold_requests++;
         // one full drain in the middle of the run
         if (i == 900) wait_drained();
         r      = $urandom_range(0, 99);
         kind   = KIND_ALLOC;
         policy = POLICY_BITS'($urandom_range(0, 2));
         owner  = owner_pool[$urandom_range(0, POOL_SIZE - 1)];
         if ($urandom_range(0, 9) == 0)       pages = PAGES_BITS'($urandom_range(25, 128));
         else if ($urandom_range(0, 29) == 0) pages = PAGES_BITS'($urandom_range(129, 256));
         else                                 pages = PAGES_BITS'($urandom_range(1, 24));
         if (r >= 55 && r < 85) begin
            kind  = KIND_RELEASE;
            pages = PAGES_BITS'($urandom_range(0, 511));
         end else if (r >= 85 && r < 88) begin
            // release of a random owner, usually one that holds nothing
            kind  = KIND_RELEASE;
            owner = OWNER_FIELD_BITS'($urandom_range(0, 65535));
         end else if (r >= 88 && r < 92) begin
            policy = POLICY_BAD;
            pages  = PAGES_BITS'($urandom_range(0, 511));
         end else if (r >= 92 && r < 95) begin
            pages = '0;
         end else if (r >= 95) begin
            pages = PAGES_BITS'($urandom_range(257, 511));
         end
         offer_item(kind, policy, owner, pages);
      end

      wait_drained();
      repeat (PAGE_COUNT + 16) @(posedge clock);
      if (error_count == 0) begin
         $display("contiguous_page_allocator_tb: clean");
      end else begin
         $display("contiguous_page_allocator_tb: errors");
      end
      $finish;
   end

endmodule
